[src/sbx_pkg.sv]
// ----------------------------------------------------------------------------
// sbx_pkg
// Shared constants, opcodes, status codes and controller/datapath types for
// the stack bytecode execute core.
// ----------------------------------------------------------------------------
package sbx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int LOCAL_COUNT = 256;
  localparam int PC_BITS     = 16;
  localparam int DATA_W      = 32;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LOC_AW      = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_POP    = 5'd1;
  localparam logic [4:0] OP_DUP    = 5'd2;
  localparam logic [4:0] OP_SWAP   = 5'd3;
  localparam logic [4:0] OP_ADD    = 5'd4;
  localparam logic [4:0] OP_SUB    = 5'd5;
  localparam logic [4:0] OP_DIV    = 5'd6;
  localparam logic [4:0] OP_REM    = 5'd7;
  localparam logic [4:0] OP_MUL    = 5'd8;
  localparam logic [4:0] OP_AND    = 5'd9;
  localparam logic [4:0] OP_OR     = 5'd10;
  localparam logic [4:0] OP_XOR    = 5'd11;
  localparam logic [4:0] OP_SHL    = 5'd12;
  localparam logic [4:0] OP_SHR    = 5'd13;
  localparam logic [4:0] OP_BIPUSH = 5'd14;
  localparam logic [4:0] OP_ILDC   = 5'd15;
  localparam logic [4:0] OP_NULL   = 5'd16;
  localparam logic [4:0] OP_VLOAD  = 5'd17;
  localparam logic [4:0] OP_VSTORE = 5'd18;
  localparam logic [4:0] OP_IFEQ   = 5'd19;
  localparam logic [4:0] OP_IFNE   = 5'd20;
  localparam logic [4:0] OP_IFLT   = 5'd21;
  localparam logic [4:0] OP_IFGE   = 5'd22;
  localparam logic [4:0] OP_IFGT   = 5'd23;
  localparam logic [4:0] OP_IFLE   = 5'd24;
  localparam logic [4:0] OP_GOTO   = 5'd25;
  localparam logic [4:0] OP_ASSERT = 5'd26;
  localparam logic [4:0] OP_RETURN = 5'd27;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DIV0   = 3'd1;
  localparam logic [2:0] ST_DIVOVF = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_ASSERT = 3'd4;
  localparam logic [2:0] ST_UNDER  = 3'd5;
  localparam logic [2:0] ST_OVER   = 3'd6;
  localparam logic [2:0] ST_HALT   = 3'd7;

  typedef struct packed {
    logic load;
    logic commit;
    logic sel_div;
    logic div_start;
    logic div_step;
    logic wr2;
  } sbx_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_wr2;
    logic div_last;
    logic out_free;
  } sbx_sts_t;

  function automatic logic [1:0] pop_need(input logic [4:0] op);
    case (op)
      OP_POP, OP_DUP, OP_VSTORE, OP_RETURN: pop_need = 2'd1;
      OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_REM, OP_MUL, OP_AND, OP_OR, OP_XOR,
      OP_SHL, OP_SHR, OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE,
      OP_ASSERT: pop_need = 2'd2;
      default: pop_need = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] push_give(input logic [4:0] op);
    case (op)
      OP_DUP, OP_SWAP: push_give = 2'd2;
      OP_ADD, OP_SUB, OP_DIV, OP_REM, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL,
      OP_SHR, OP_BIPUSH, OP_ILDC, OP_NULL, OP_VLOAD: push_give = 2'd1;
      default: push_give = 2'd0;
    endcase
  endfunction

endpackage

[src/sbx_ram.sv]
// ----------------------------------------------------------------------------
// sbx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sbx_ctrl.sv]
// ----------------------------------------------------------------------------
// sbx_ctrl
// Sequencer for one instruction: fetch operands, execute or divide, commit,
// and a second stack write for swap.
module sbx_ctrl
  import sbx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sbx_sts_t sts,
  output sbx_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_WR2  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.need_wr2 ? S_WR2 : S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.sel_div = 1'b1;
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/sbx_dpath.sv]
// ----------------------------------------------------------------------------
// sbx_dpath
// Datapath: operand stack and local store RAMs, ALU, serial divider, program
// counter, halt flag and the result register.
// ----------------------------------------------------------------------------
module sbx_dpath
  import sbx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sbx_cmd_t           cmd,
  output sbx_sts_t           sts,
  input  logic [4:0]         in_mode,
  input  logic signed [15:0] in_immediate,
  input  logic signed [31:0] in_pool_constant,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_next_pc,
  output logic signed [31:0] out_return_value
);

  logic [4:0]           mode_r;
  logic signed [15:0]   imm_r;
  logic [DATA_W-1:0]    pool_r;
  logic [CNT_W-1:0]     count_r;
  logic [PC_BITS-1:0]   pc_r;
  logic                 halted_r;
  logic [DATA_W-1:0]    hold_r;
  logic                 out_valid_r;
  logic [2:0]           status_r;
  logic [15:0]          npc_r;
  logic [DATA_W-1:0]    rv_r;
  logic [LOCAL_COUNT-1:0] lvalid_r;
  logic                 lval_q_r;

  logic [DATA_W:0]      drem_r;
  logic [DATA_W-1:0]    dquo_r;
  logic [DATA_W-1:0]    ddiv_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  logic [DATA_W-1:0] a, b, lrd, ldata;
  logic [4:0]        op;
  logic [1:0]        npop, npush;
  logic [CNT_W:0]    cnt_after;
  logic              under, over, div0, divovf, badsh, asfail, fault;
  logic [2:0]        fstatus;
  logic [LOC_AW-1:0] slot;
  logic [DATA_W-1:0] r, div_res;
  logic              take, is_br;
  logic [PC_BITS-1:0] imm_pc, pc_new;
  logic [STK_AW-1:0] s_waddr, rd0_addr, rd1_addr;
  logic              s_we;
  logic [DATA_W-1:0] s_wdata;
  logic              l_we;
  logic [DATA_W:0]   dtrial;

  // ---- operand RAMs: two mirrored copies give the top two words at once ----
  assign rd0_addr = STK_AW'(count_r - CNT_W'(1));
  assign rd1_addr = STK_AW'(count_r - CNT_W'(2));

  sbx_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stk0 (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(rd0_addr), .rdata(a)
  );
  sbx_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stk1 (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(rd1_addr), .rdata(b)
  );

  assign slot = LOC_AW'(imm_r[7:0] % LOCAL_COUNT);

  sbx_ram #(.WIDTH(DATA_W), .DEPTH(LOCAL_COUNT)) u_loc (
    .clk(clk), .we(l_we), .waddr(slot), .wdata(a),
    .raddr(slot), .rdata(lrd)
  );

  // A local that was never written reads as zero.
  assign ldata = lval_q_r ? lrd : '0;

  // ---- decode and fault checks ----
  always_comb begin
    op        = (mode_r > OP_RETURN) ? OP_NOP : mode_r;
    npop      = pop_need(op);
    npush     = push_give(op);
    cnt_after = {1'b0, count_r} - (CNT_W + 1)'(npop) + (CNT_W + 1)'(npush);
    under     = count_r < CNT_W'(npop);
    over      = cnt_after > (CNT_W + 1)'(STACK_DEPTH);
    div0      = (op == OP_DIV || op == OP_REM) && (a == '0);
    divovf    = (op == OP_DIV || op == OP_REM) && (b == 32'h8000_0000) &&
                (a == 32'hFFFF_FFFF);
    badsh     = (op == OP_SHL || op == OP_SHR) && (a[DATA_W-1:5] != '0);
    asfail    = (op == OP_ASSERT) && (b == '0);
    fault     = under || over || div0 || divovf || badsh || asfail;
    if (under) begin
      fstatus = ST_UNDER;
    end else if (over) begin
      fstatus = ST_OVER;
    end else if (div0) begin
      fstatus = ST_DIV0;
    end else if (divovf) begin
      fstatus = ST_DIVOVF;
    end else if (badsh) begin
      fstatus = ST_SHIFT;
    end else begin
      fstatus = ST_ASSERT;
    end
  end

  assign sts.need_div = !halted_r && !fault && (op == OP_DIV || op == OP_REM);
  assign sts.need_wr2 = !halted_r && !fault && (op == OP_SWAP);
  assign sts.div_last = (dcnt_r == DIV_CNT_W'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // ---- serial divider on magnitudes, one quotient bit per cycle ----
  assign dtrial = {drem_r[DATA_W-1:0], dquo_r[DATA_W-1]} - {1'b0, ddiv_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem_r <= '0;
      dquo_r <= b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
      ddiv_r <= a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
      dcnt_r <= DIV_CNT_W'(DATA_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DIV_CNT_W'(1);
      if (!dtrial[DATA_W]) begin
        drem_r <= dtrial;
        dquo_r <= {dquo_r[DATA_W-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[DATA_W-1:0], dquo_r[DATA_W-1]};
        dquo_r <= {dquo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (op == OP_DIV) begin
      div_res = (a[DATA_W-1] ^ b[DATA_W-1]) ? (~dquo_r + DATA_W'(1)) : dquo_r;
    end else begin
      div_res = b[DATA_W-1] ? (~drem_r[DATA_W-1:0] + DATA_W'(1)) :
                drem_r[DATA_W-1:0];
    end
  end

  // ---- result word ----
  always_comb begin
    case (op)
      OP_DUP:    r = a;
      OP_SWAP:   r = b;
      OP_ADD:    r = b + a;
      OP_SUB:    r = b - a;
      OP_MUL:    r = b * a;
      OP_AND:    r = b & a;
      OP_OR:     r = b | a;
      OP_XOR:    r = b ^ a;
      OP_SHL:    r = b << a[4:0];
      OP_SHR:    r = DATA_W'($signed(b) >>> a[4:0]);
      OP_BIPUSH: r = {{(DATA_W - 8){imm_r[7]}}, imm_r[7:0]};
      OP_ILDC:   r = pool_r;
      OP_VLOAD:  r = ldata;
      default:   r = '0;
    endcase
    if (cmd.sel_div) begin
      r = div_res;
    end
  end

  // ---- next program counter ----
  always_comb begin
    imm_pc = PC_BITS'(imm_r);
    is_br  = 1'b0;
    case (op)
      OP_IFEQ: begin take = (b == a);                   is_br = 1'b1; end
      OP_IFNE: begin take = (b != a);                   is_br = 1'b1; end
      OP_IFLT: begin take = ($signed(b) <  $signed(a)); is_br = 1'b1; end
      OP_IFGE: begin take = ($signed(b) >= $signed(a)); is_br = 1'b1; end
      OP_IFGT: begin take = ($signed(b) >  $signed(a)); is_br = 1'b1; end
      OP_IFLE: begin take = ($signed(b) <= $signed(a)); is_br = 1'b1; end
      default: take = 1'b0;
    endcase
    if (is_br) begin
      pc_new = take ? (pc_r + imm_pc) : (pc_r + PC_BITS'(3));
    end else begin
      case (op)
        OP_BIPUSH, OP_VLOAD, OP_VSTORE: pc_new = pc_r + PC_BITS'(2);
        OP_ILDC: pc_new = pc_r + PC_BITS'(3);
        OP_GOTO: pc_new = pc_r + imm_pc;
        default: pc_new = pc_r + PC_BITS'(1);
      endcase
    end
  end

  // ---- memory writes ----
  always_comb begin
    s_we    = 1'b0;
    s_waddr = STK_AW'(cnt_after - (CNT_W + 1)'(1));
    s_wdata = r;
    if (cmd.wr2) begin
      s_we    = 1'b1;
      s_waddr = rd1_addr;
      s_wdata = hold_r;
    end else if (cmd.commit && !halted_r && !fault && npush != 2'd0) begin
      s_we = 1'b1;
    end
  end

  assign l_we = cmd.commit && !halted_r && !fault && (op == OP_VSTORE);

  // ---- architectural state and result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lvalid_r    <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (!halted_r) begin
          halted_r <= fault || (op == OP_RETURN);
          if (!fault) begin
            count_r <= CNT_W'(cnt_after);
            pc_r    <= pc_new;
          end
        end
      end
      if (l_we) begin
        lvalid_r[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lval_q_r <= lvalid_r[slot];
    if (cmd.load) begin
      mode_r <= in_mode;
      imm_r  <= in_immediate;
      pool_r <= in_pool_constant;
    end
    if (cmd.commit) begin
      hold_r <= a;
      rv_r   <= '0;
      if (halted_r) begin
        status_r <= ST_HALT;
        npc_r    <= 16'(pc_r);
      end else if (fault) begin
        status_r <= fstatus;
        npc_r    <= 16'(pc_r);
      end else begin
        status_r <= (op == OP_RETURN) ? ST_HALT : ST_OK;
        npc_r    <= 16'(pc_new);
        if (op == OP_RETURN) begin
          rv_r <= a;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_next_pc      = npc_r;
  assign out_return_value = rv_r;

endmodule

[src/stack_bytecode_execute_core_unit.sv]
// Sequence: an accepted beat is registered, the top stack words are read from
// the registered RAMs, then the result is committed to the result register;
// div and rem first run the serial divider, one quotient bit per cycle, and
// swap adds a second stack write. A commit waits while the pending result is
// stalled, and a new beat is accepted only once the sequence is back in idle.
// Reset: synchronous active-low rst_n clears the stack count, program counter,
// halt flag, result valid and the per-entry valid bits of the local store.
// ----------------------------------------------------------------------------
// stack_bytecode_execute_core_unit
// Executes one decoded stack-machine instruction per input beat and returns
// one status beat with the next program counter and any return value.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_core_unit
  import sbx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_mode,
  input  logic signed [15:0] in_immediate,
  input  logic signed [31:0] in_pool_constant,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_next_pc,
  output logic signed [31:0] out_return_value
);

  sbx_cmd_t cmd;
  sbx_sts_t sts;

  sbx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  sbx_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_immediate(in_immediate),
    .in_pool_constant(in_pool_constant),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_next_pc(out_next_pc), .out_return_value(out_return_value)
  );

  // Only one instruction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted while an instruction is in flight");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not produce a result beat");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.commit, cmd.div_start, cmd.div_step, cmd.wr2}))
    else $error("conflicting datapath commands");

  a_commit_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit overwrote a pending result");

endmodule

[test/tb_stack_bytecode_execute_core_unit.sv]
// ----------------------------------------------------------------------------
// tb_stack_bytecode_execute_core_unit
// Drives random and directed instruction streams into the execute core and
// checks each status beat against a behavioral model of the stack machine
// kept in the scoreboard. Reset is applied once, so programs are built to
// stay clear of faults until a late phase that overflows the stack.
// ----------------------------------------------------------------------------
module tb_stack_bytecode_execute_core_unit;
  import sbx_pkg::*;

  class exec_scoreboard;
    logic [31:0] stk[STACK_DEPTH];
    logic [31:0] locals[LOCAL_COUNT];
    int          depth;
    logic [15:0] pc;
    bit          halted;
    logic [2:0]  exp_status[$];
    logic [15:0] exp_pc[$];
    logic [31:0] exp_rv[$];
    int          errors;

    function void clear();
      depth = 0;
      pc = '0;
      halted = 0;
      errors = 0;
      foreach (locals[i]) locals[i] = '0;
    endfunction

    function void post(logic [2:0] st, logic [15:0] npc, logic [31:0] rv);
      exp_status.push_back(st);
      exp_pc.push_back(npc);
      exp_rv.push_back(rv);
    endfunction

    function void fault(logic [2:0] st);
      halted = 1;
      post(st, pc, '0);
    endfunction

    function void note_instr(logic [4:0] mode_in, logic [15:0] imm16, logic [31:0] pool);
      logic [4:0]  op;
      int          npop, npush;
      logic [31:0] a, b, r, imm;
      bit          take;
      op = (mode_in > OP_RETURN) ? OP_NOP : mode_in;
      imm = {{16{imm16[15]}}, imm16};
      a = '0;
      b = '0;
      r = '0;
      take = 0;
      if (halted) begin
        post(ST_HALT, pc, '0);
        return;
      end
      npop = pop_need(op);
      npush = push_give(op);
      if (depth < npop) begin
        fault(ST_UNDER);
        return;
      end
      if (depth - npop + npush > STACK_DEPTH) begin
        fault(ST_OVER);
        return;
      end
      if (npop >= 1) a = stk[depth-1];
      if (npop >= 2) b = stk[depth-2];
      if ((op == OP_DIV || op == OP_REM) && a == 0) begin
        fault(ST_DIV0);
        return;
      end
      if ((op == OP_DIV || op == OP_REM) && b == 32'h8000_0000 && a == 32'hFFFF_FFFF) begin
        fault(ST_DIVOVF);
        return;
      end
      if ((op == OP_SHL || op == OP_SHR) && a > 31) begin
        fault(ST_SHIFT);
        return;
      end
      if (op == OP_ASSERT && b == 0) begin
        fault(ST_ASSERT);
        return;
      end
      depth -= npop;
      case (op)
        OP_DUP: begin
          r = a;
          stk[depth++] = a;
        end
        OP_SWAP: begin
          stk[depth++] = a;
          r = b;
        end
        OP_ADD: r = b + a;
        OP_SUB: r = b - a;
        OP_DIV: r = $signed(b) / $signed(a);
        OP_REM: r = $signed(b) % $signed(a);
        OP_MUL: r = b * a;
        OP_AND: r = b & a;
        OP_OR: r = b | a;
        OP_XOR: r = b ^ a;
        OP_SHL: r = b << a[4:0];
        OP_SHR: r = $signed(b) >>> a[4:0];
        OP_BIPUSH: r = {{24{imm[7]}}, imm[7:0]};
        OP_ILDC: r = pool;
        OP_VLOAD: r = locals[imm[7:0]];
        OP_VSTORE: locals[imm[7:0]] = a;
        default: ;
      endcase
      if (npush >= 1) stk[depth++] = r;
      case (op)
        OP_BIPUSH, OP_VLOAD, OP_VSTORE: pc += 16'd2;
        OP_ILDC: pc += 16'd3;
        OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE: begin
          case (op)
            OP_IFEQ: take = (b == a);
            OP_IFNE: take = (b != a);
            OP_IFLT: take = $signed(b) < $signed(a);
            OP_IFGE: take = $signed(b) >= $signed(a);
            OP_IFGT: take = $signed(b) > $signed(a);
            default: take = $signed(b) <= $signed(a);
          endcase
          pc = take ? pc + imm16 : pc + 16'd3;
        end
        OP_GOTO: pc += imm16;
        default: pc += 16'd1;
      endcase
      if (op == OP_RETURN) begin
        halted = 1;
        post(ST_HALT, pc, a);
      end else begin
        post(ST_OK, pc, '0);
      end
    endfunction

    function void check_beat(logic [2:0] st, logic [15:0] npc, logic [31:0] rv);
      logic [2:0]  es;
      logic [15:0] ep;
      logic [31:0] er;
      if (exp_status.size() == 0) begin
        $error("unexpected result beat: status %0d next_pc %0d", st, npc);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ep = exp_pc.pop_front();
      er = exp_rv.pop_front();
      if (st !== es) begin
        $error("status: expected %0d, got %0d", es, st);
        errors++;
      end
      if (npc !== ep) begin
        $error("next_pc: expected %0d, got %0d", ep, npc);
        errors++;
      end
      if (rv !== er) begin
        $error("return_value: expected %0h, got %0h", er, rv);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [4:0]         in_mode;
  logic signed [15:0] in_immediate;
  logic signed [31:0] in_pool_constant;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [15:0]        out_next_pc;
  logic signed [31:0] out_return_value;

  exec_scoreboard sb;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_off;
  int n_sent;

  stack_bytecode_execute_core_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_immediate(in_immediate),
    .in_pool_constant(in_pool_constant),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_next_pc(out_next_pc),
    .out_return_value(out_return_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sends one instruction, with an optional random gap before it. Valid stays
  // high after a beat is taken, so the next call must follow at once or the
  // caller drops it.
  task automatic send_instr(logic [4:0] m, logic [15:0] imm, logic [31:0] pool);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_immediate <= imm;
    in_pool_constant <= pool;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instr(m, imm, pool);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // A random instruction that cannot fault given the current model state.
  task automatic send_safe();
    logic [4:0]  m;
    logic [31:0] a, b;
    int d;
    bit ok;
    ok = 0;
    while (!ok) begin
      d = sb.depth;
      m = 5'($urandom_range(0, 31));
      if (m == OP_RETURN || m == OP_ASSERT && d < 2) continue;
      if (m <= OP_RETURN && d < pop_need(m)) begin
        send_instr(OP_ILDC, 16'($urandom), rand_word());
        continue;
      end
      if (m <= OP_RETURN && d - pop_need(m) + push_give(m) > STACK_DEPTH) continue;
      a = (d >= 1) ? sb.stk[d-1] : '0;
      b = (d >= 2) ? sb.stk[d-2] : '0;
      if ((m == OP_DIV || m == OP_REM) && (a == 0 || b == 32'h8000_0000 && a == '1)) continue;
      if ((m == OP_SHL || m == OP_SHR) && a > 31) continue;
      if (m == OP_ASSERT && b == 0) continue;
      ok = 1;
    end
    send_instr(m, 16'($urandom), $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_status, out_next_pc, out_return_value);
  end

  always @(posedge clk) begin
    int burst;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 16);
      out_stall <= 1'b1;
      repeat (burst) @(posedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int k;
    sb = new();
    sb.clear();
    n_sent = 0;
    send_idle_on = 1;
    recv_idle_on = 1;
    hold_off = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_immediate = '0;
    in_pool_constant = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of each field and a sample of the operations.
    send_instr(OP_VLOAD, 16'h00FF, '0);
    send_instr(OP_BIPUSH, 16'h807F, '0);
    send_instr(OP_BIPUSH, 16'h0080, '0);
    send_instr(OP_ILDC, 16'h7FFF, 32'h8000_0000);
    send_instr(OP_ILDC, 16'h8000, 32'h7FFF_FFFF);
    send_instr(OP_SUB, '0, '0);
    send_instr(OP_NULL, '0, 32'hFFFF_FFFF);
    send_instr(OP_IFEQ, 16'hFFFE, '0);
    send_instr(OP_DUP, '0, '0);
    send_instr(OP_SWAP, '0, '0);
    send_instr(5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    send_instr(OP_VSTORE, 16'h1203, '0);
    send_instr(OP_VLOAD, 16'h0003, '0);
    send_instr(OP_BIPUSH, 16'd31, '0);
    send_instr(OP_SHR, '0, '0);
    send_instr(OP_GOTO, 16'h8000, '0);
    send_instr(OP_POP, '0, '0);

    // Long receiver hold-off while the sender keeps going.
    send_idle_on = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (40) send_safe();
    join
    send_idle_on = 1;

    // Random programs of safe instructions; a fault or return leaves the block
    // stuck halted, so only the later phases may halt it.
    while (n_sent < 230) send_safe();

    // Fill to overflow edge.
    while (sb.depth < STACK_DEPTH) send_instr(OP_BIPUSH, 16'($urandom), '0);
    send_instr(OP_DUP, '0, '0);
    while (n_sent < 470) send_safe();
    recv_idle_on = 0;
    send_idle_on = 0;
    if (sb.depth >= 2) begin
      send_instr(OP_ILDC, '0, 32'd1);
      send_instr(OP_BIPUSH, 16'd9, '0);
      send_instr(OP_ASSERT, '0, '0);
      k = $urandom_range(0, 4);
      case (k)
        0: send_instr(OP_NULL, '0, '0);
        1: send_instr(OP_BIPUSH, 16'hFFFF, '0);
        2: send_instr(OP_BIPUSH, 16'd40, '0);
        3: send_instr(OP_ILDC, '0, '0);
        default: send_instr(OP_RETURN, '0, '0);
      endcase
      case (k)
        0: send_instr(OP_DIV, '0, '0);
        1: send_instr(OP_REM, '0, '0);
        2: send_instr(OP_SHL, '0, '0);
        3: send_instr(OP_ASSERT, '0, '0);
        default: ;
      endcase
    end
    while (sb.depth > 0 && !sb.halted) send_instr(OP_POP, '0, '0);
    send_instr(OP_POP, '0, '0);
    for (k = 0; k < 8; k++)
      send_instr(5'($urandom_range(0, 31)), 16'($urandom), $urandom);
    in_valid <= 1'b0;

    k = 0;
    while (sb.exp_status.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[stack_bytecode_execute_core_unit.f]
src/sbx_pkg.sv
src/sbx_ram.sv
src/sbx_ctrl.sv
src/sbx_dpath.sv
src/stack_bytecode_execute_core_unit.sv
test/tb_stack_bytecode_execute_core_unit.sv
